FILE: rtl/b64d_pkg.sv
// Package: shared constants, types and the alphabet lookup of the Base64 stream decoder.
package b64d_pkg;

  localparam int MaxOutputBytes = 65536;
  localparam int CntW           = 17;       // byte_count / out_capacity field width
  localparam int LimW           = CntW + 1; // room for count plus three
  localparam int AccW           = 25;       // four sextets behind a sentinel bit
  localparam int QueueDepth     = 4;
  localparam int QPtrW          = $clog2(QueueDepth);

  localparam logic [CntW-1:0] CapReset = CntW'(65536);
  localparam logic [LimW-1:0] MaxLim   = LimW'(MaxOutputBytes);

  // lookup codes beyond the 64 alphabet values
  localparam logic [6:0] CodeSkip = 7'd64;
  localparam logic [6:0] CodePad  = 7'd65;
  localparam logic [6:0] CodeBad  = 7'd66;

  // status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusInvalid  = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // register map
  localparam int          AddrW        = 3;
  localparam logic [0:0]  RegOutCapIdx = 1'b0;

  // one input word's worth of results: up to three bytes, then an optional status word
  typedef struct packed {
    logic [2:0][7:0]  data;
    logic [1:0]       ndata;
    logic             has_status;
    logic [1:0]       status;
    logic [CntW-1:0]  count;
  } job_t;

  function automatic logic [6:0] map_symbol(input logic [7:0] ch);
    logic [6:0] v;
    v = CodeBad;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = 7'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = 7'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = 7'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      v = 7'd62;
    end else if (ch == 8'h2F) begin
      v = 7'd63;
    end else if (ch == 8'h09) begin
      v = CodeSkip;
    end else if (ch == 8'h3D) begin
      v = CodePad;
    end
    return v;
  endfunction

endpackage

FILE: rtl/b64d_if.sv
// Interfaces: character input stream and decoded output stream.
interface b64d_in_if;
  import b64d_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_present;
  logic       end_of_message;

  modport source (output valid, symbol, symbol_present, end_of_message, input ready);
  modport sink   (input valid, symbol, symbol_present, end_of_message, output ready);
endinterface

interface b64d_out_if;
  import b64d_pkg::*;
  logic            valid;
  logic            ready;
  logic [7:0]      out_byte;
  logic            is_data;
  logic [1:0]      status;
  logic [CntW-1:0] byte_count;
  logic            last;

  modport source (output valid, out_byte, is_data, status, byte_count, last, input ready);
  modport sink   (input valid, out_byte, is_data, status, byte_count, last, output ready);
endinterface

FILE: rtl/b64d_front.sv
// Front end: maps characters, collects sextets, tracks count and errors, builds result jobs.
module b64d_front
  import b64d_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      symbol_i,
  input  logic            symbol_present_i,
  input  logic            end_of_message_i,
  input  logic [CntW-1:0] out_capacity_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [AccW-1:0] acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            stopped_q, stopped_d;
  logic [1:0]      err_q, err_d;

  logic [6:0]      code;
  logic [AccW-1:0] acc_shift;
  logic [LimW-1:0] lim;
  logic [LimW-1:0] cnt_ext;
  logic [AccW-1:0] acc_n;
  logic [CntW-1:0] cnt_n;
  logic            stopped_n;
  logic [1:0]      err_n;
  job_t            job;

  always_comb begin
    code      = map_symbol(symbol_i);
    acc_shift = {acc_q[AccW-7:0], code[5:0]};
    lim       = ({1'b0, out_capacity_i} > MaxLim) ? MaxLim : {1'b0, out_capacity_i};
    cnt_ext   = {1'b0, cnt_q};

    acc_n     = acc_q;
    cnt_n     = cnt_q;
    stopped_n = stopped_q;
    err_n     = err_q;
    job       = '0;

    if (symbol_present_i && !stopped_q) begin
      if (code == CodeBad) begin
        err_n     = StatusInvalid;
        stopped_n = 1'b1;
      end else if (code == CodePad) begin
        stopped_n = 1'b1;
      end else if (code != CodeSkip) begin
        acc_n = acc_shift;
        if (acc_shift[AccW-1]) begin
          if (cnt_ext + LimW'(3) > lim) begin
            err_n     = StatusOverflow;
            stopped_n = 1'b1;
          end else begin
            job.data[0] = acc_shift[23:16];
            job.data[1] = acc_shift[15:8];
            job.data[2] = acc_shift[7:0];
            job.ndata   = 2'd3;
            cnt_n       = CntW'(cnt_ext + LimW'(3));
          end
          acc_n = AccW'(1);
        end
      end
    end

    if (end_of_message_i) begin
      if (err_n == StatusOk) begin
        if (acc_n[18]) begin
          // three sextets left: two bytes
          if ({1'b0, cnt_n} + LimW'(2) > lim) begin
            err_n = StatusOverflow;
          end else begin
            job.data[0] = acc_n[17:10];
            job.data[1] = acc_n[9:2];
            job.ndata   = 2'd2;
            cnt_n       = CntW'({1'b0, cnt_n} + LimW'(2));
          end
        end else if (acc_n[12]) begin
          // two sextets left: one byte
          if ({1'b0, cnt_n} + LimW'(1) > lim) begin
            err_n = StatusOverflow;
          end else begin
            job.data[0] = acc_n[11:4];
            job.ndata   = 2'd1;
            cnt_n       = CntW'({1'b0, cnt_n} + LimW'(1));
          end
        end
      end
      job.has_status = 1'b1;
      job.status     = err_n;
      job.count      = cnt_n;
      // re-arm for the next message
      acc_n     = AccW'(1);
      cnt_n     = '0;
      stopped_n = 1'b0;
      err_n     = StatusOk;
    end

    acc_d     = accept_i ? acc_n     : acc_q;
    cnt_d     = accept_i ? cnt_n     : cnt_q;
    stopped_d = accept_i ? stopped_n : stopped_q;
    err_d     = accept_i ? err_n     : err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= AccW'(1);
      cnt_q     <= '0;
      stopped_q <= 1'b0;
      err_q     <= StatusOk;
    end else begin
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
      err_q     <= err_d;
    end
  end

  assign push_o = accept_i && (job.ndata != 2'd0 || job.has_status);
  assign job_o  = job;

endmodule

FILE: rtl/b64d_queue.sv
// Job queue: small register FIFO between the front end and the output sequencer.
module b64d_queue
  import b64d_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  job_t             entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   fill_q, fill_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + (QPtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  assign full_o  = (fill_q == (QPtrW+1)'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

endmodule

FILE: rtl/b64d_back.sv
// Back end: walks the head job one result word per cycle into the output register, while the output is not stalled.
module b64d_back
  import b64d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  job_t              head_i,
  output logic              pop_o,
  b64d_out_if.source        out_o
);

  logic [1:0]      idx_q, idx_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            is_data_q, is_data_d;
  logic [1:0]      status_q, status_d;
  logic [CntW-1:0] count_q, count_d;
  logic            last_q, last_d;

  logic [2:0]      total;
  logic            issue;
  logic            item_last;
  logic            item_data;

  always_comb begin
    total     = {1'b0, head_i.ndata} + {2'b00, head_i.has_status};
    issue     = !empty_i && (!valid_q || out_o.ready);
    item_last = ({1'b0, idx_q} == total - 3'd1);
    item_data = (idx_q < head_i.ndata);

    idx_d     = idx_q;
    valid_d   = valid_q && !out_o.ready;
    byte_d    = byte_q;
    is_data_d = is_data_q;
    status_d  = status_q;
    count_d   = count_q;
    last_d    = last_q;

    if (issue) begin
      valid_d   = 1'b1;
      is_data_d = item_data;
      last_d    = item_last;
      if (item_data) begin
        byte_d   = head_i.data[idx_q];
        status_d = StatusOk;
        count_d  = '0;
      end else begin
        byte_d   = '0;
        status_d = head_i.status;
        count_d  = head_i.count;
      end
      // advance within the job, or retire it on its last word
      idx_d = item_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    is_data_q <= is_data_d;
    status_q  <= status_d;
    count_q   <= count_d;
    last_q    <= last_d;
  end

  assign pop_o             = issue && item_last;
  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.is_data     = is_data_q;
  assign out_o.status      = status_q;
  assign out_o.byte_count  = count_q;
  assign out_o.last        = last_q;

endmodule

FILE: rtl/base64_stream_decoder.sv
// Top level: Base64 stream decoder with APB capacity register.
//
//  channel   dir  handshake          payload
//  in_i      in   valid/ready        symbol, symbol_present, end_of_message
//  out_o     out  valid/ready        out_byte, is_data, status, byte_count, last
//  apb       in   psel/penable/...   out_capacity at byte address 0
//
// One character is taken per cycle; the front end classifies it in that cycle and
// queues up to four result words (three bytes and a status word).
// Results leave one per cycle from the output register while the receiver is ready;
// the first word of a job passes from the job queue into the output register.
// in_i.ready drops only while the four-entry job queue is full.
// Reset is asynchronous, active low; out_capacity resets to 65536.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  b64d_in_if.sink           in_i,
  b64d_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [CntW-1:0] cap_q, cap_d;
  logic            cfg_wr;
  logic            accept;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  job_t            job;
  job_t            head;

  // capacity register
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrW-1:2] == RegOutCapIdx);
  assign cap_d  = cfg_wr ? pwdata[CntW-1:0] : cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[AddrW-1:2] == RegOutCapIdx) ? {{(32-CntW){1'b0}}, cap_q} : '0;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  b64d_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .symbol_i         (in_i.symbol),
    .symbol_present_i (in_i.symbol_present),
    .end_of_message_i (in_i.end_of_message),
    .out_capacity_i   (cap_q),
    .push_o           (push),
    .job_o            (job)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // never push into a full queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("job queue overrun");

  // a status word always closes its run
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_data) |-> out_o.last)
    else $error("status word not marked last");

  // a new output word needs a queued job the cycle before
  a_out_from_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!empty))
    else $error("output word without queued job");

endmodule

FILE: test/base64_stream_decoder_tb.sv
// Testbench for the Base64 stream decoder: directed rows, random messages, per-word checks.
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkHalf       = 5;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 1000;
  localparam int RandomItems   = 330;
  localparam int MaxReports    = 40;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            is_data;
    logic [1:0]      status;
    logic [CntW-1:0] byte_count;
    logic            last;
  } decoded_t;

  typedef enum logic {RowWord, RowCap} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  sym;
    logic        pres;
    logic        eom;
    logic        typed;   // status word typed in below, predictor output not used
    logic [1:0]  st;
    logic [17:0] val;     // byte count of a typed row, or capacity of a register row
  } dir_row_t;

  localparam int NumRows = 26;
  localparam dir_row_t DirRows [NumRows] = '{
    '{RowWord, 8'h00, 1'b0, 1'b1, 1'b1, StatusOk,       18'd0},  // end-only after reset
    '{RowWord, "T",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, 8'h09, 1'b1, 1'b0, 1'b0, StatusOk,       18'd0},  // tab is skipped
    '{RowWord, "W",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "F",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "u",   1'b1, 1'b1, 1'b0, StatusOk,       18'd0},  // full group at end
    '{RowWord, "+",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "/",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "z",   1'b1, 1'b1, 1'b0, StatusOk,       18'd0},  // three values flush
    '{RowWord, "Z",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "9",   1'b1, 1'b1, 1'b0, StatusOk,       18'd0},  // two values flush
    '{RowWord, "a",   1'b1, 1'b1, 1'b1, StatusOk,       18'd0},  // lone value, no byte
    '{RowWord, "0",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "A",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "=",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},  // pad stops the message
    '{RowWord, 8'hFF, 1'b1, 1'b0, 1'b0, StatusOk,       18'd0},  // ignored after pad
    '{RowWord, 8'h00, 1'b0, 1'b1, 1'b0, StatusOk,       18'd0},  // partial group still flushes
    '{RowWord, 8'h00, 1'b1, 1'b1, 1'b1, StatusInvalid,  18'd0},
    '{RowWord, " ",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},  // space is invalid
    '{RowWord, "Q",   1'b1, 1'b1, 1'b1, StatusInvalid,  18'd0},
    '{RowCap,  8'h00, 1'b0, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "/",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "/",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "/",   1'b1, 1'b0, 1'b0, StatusOk,       18'd0},
    '{RowWord, "/",   1'b1, 1'b1, 1'b1, StatusOverflow, 18'd0},  // no room for any byte
    '{RowCap,  8'h00, 1'b0, 1'b0, 1'b0, StatusOk,       18'd65536}
  };

  localparam int NumPhases = 6;
  localparam logic [CntW-1:0] PhaseCaps [NumPhases] = '{
    17'd3, 17'd131071, 17'd0, 17'd9, 17'd40, 17'd65536
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // decoder shadow state
  logic [CntW-1:0] cap_shadow;
  logic [AccW-1:0] group_acc;
  logic [CntW-1:0] bytes_out;
  logic            halted;
  logic [1:0]      err_st;

  decoded_t expected_q[$];

  int fail_count  = 0;
  int items_sent  = 0;
  int words_seen  = 0;
  int bytes_seen  = 0;
  int status_seen [3] = '{0, 0, 0};
  int cap_writes  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] code;
    code = CodeBad;
    if (ch >= "A" && ch <= "Z") code = 7'(ch - "A");
    else if (ch >= "a" && ch <= "z") code = 7'(ch - "a") + 7'd26;
    else if (ch >= "0" && ch <= "9") code = 7'(ch - "0") + 7'd52;
    else if (ch == "+") code = 7'd62;
    else if (ch == "/") code = 7'd63;
    else if (ch == 8'h09) code = CodeSkip;
    else if (ch == "=") code = CodePad;
    return code;
  endfunction

  function automatic logic [7:0] char_of(input int v);
    logic [7:0] ch;
    if (v < 26) ch = 8'("A" + v);
    else if (v < 52) ch = 8'("a" + v - 26);
    else if (v < 62) ch = 8'("0" + v - 52);
    else if (v == 62) ch = "+";
    else ch = "/";
    return ch;
  endfunction

  function automatic decoded_t data_word(input logic [7:0] b);
    decoded_t d;
    d = '0;
    d.out_byte = b;
    d.is_data  = 1'b1;
    return d;
  endfunction

  task automatic decoder_reset();
    cap_shadow = CapReset;
    group_acc  = AccW'(1);
    bytes_out  = '0;
    halted     = 1'b0;
    err_st     = StatusOk;
  endtask

  // advance the shadow decoder by one accepted word, collect the words it emits
  task automatic decode_word(input logic [7:0] sym, input logic pres, input logic eom,
                             output decoded_t res[$]);
    logic [6:0]      code;
    logic [AccW-1:0] acc;
    int              lim;
    decoded_t        st_word;
    res = {};
    lim = (int'(cap_shadow) > MaxOutputBytes) ? MaxOutputBytes : int'(cap_shadow);
    acc = group_acc;
    if (pres && !halted) begin
      code = sextet_of(sym);
      if (code == CodeBad) begin
        err_st = StatusInvalid;
        halted = 1'b1;
      end else if (code == CodePad) begin
        halted = 1'b1;
      end else if (code != CodeSkip) begin
        acc = {acc[AccW-7:0], code[5:0]};
        if (acc[AccW-1]) begin
          if (int'(bytes_out) + 3 > lim) begin
            err_st = StatusOverflow;
            halted = 1'b1;
          end else begin
            res.push_back(data_word(acc[23:16]));
            res.push_back(data_word(acc[15:8]));
            res.push_back(data_word(acc[7:0]));
            bytes_out = bytes_out + CntW'(3);
          end
          acc = AccW'(1);
        end
      end
    end
    group_acc = acc;
    if (eom) begin
      if (err_st == StatusOk) begin
        if (acc[18]) begin
          if (int'(bytes_out) + 2 > lim) begin
            err_st = StatusOverflow;
          end else begin
            res.push_back(data_word(acc[17:10]));
            res.push_back(data_word(acc[9:2]));
            bytes_out = bytes_out + CntW'(2);
          end
        end else if (acc[12]) begin
          if (int'(bytes_out) + 1 > lim) begin
            err_st = StatusOverflow;
          end else begin
            res.push_back(data_word(acc[11:4]));
            bytes_out = bytes_out + CntW'(1);
          end
        end
      end
      st_word = '0;
      st_word.status     = err_st;
      st_word.byte_count = bytes_out;
      res.push_back(st_word);
      group_acc = AccW'(1);
      bytes_out = '0;
      halted    = 1'b0;
      err_st    = StatusOk;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endtask

  task automatic send_word(input logic [7:0] sym, input logic pres, input logic eom,
                           input logic typed, input logic [1:0] st,
                           input logic [CntW-1:0] cnt);
    decoded_t res[$];
    decoded_t st_word;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.symbol         <= sym;
    in_ch.symbol_present <= pres;
    in_ch.end_of_message <= eom;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    decode_word(sym, pres, eom, res);
    if (typed) begin
      st_word = '0;
      st_word.status     = st;
      st_word.byte_count = cnt;
      st_word.last       = 1'b1;
      expected_q.push_back(st_word);
    end else begin
      foreach (res[i]) expected_q.push_back(res[i]);
    end
  endtask

  // hold the input until all results are out and the pipeline has emptied
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CntW-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * RegOutCapIdx);
    pwdata  <= 32'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_shadow = cap;
    cap_writes++;
  endtask

  // one message: mostly alphabet characters, some tabs, noise, pads and empty items
  task automatic send_message();
    int         len;
    int         r;
    logic [7:0] ch;
    logic       sep_end;
    logic       padded;
    len = $urandom_range(0, 13);
    if ($urandom_range(0, 15) == 0) len = $urandom_range(14, 40);
    padded  = ($urandom_range(0, 3) == 0);
    sep_end = (len == 0 && !padded) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) ch = 8'h09;
      else if (r < 8) ch = 8'($urandom_range(0, 255));
      else ch = char_of($urandom_range(0, 63));
      if (r >= 8 && r < 10) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, StatusOk, '0);
      end
      send_word(ch, 1'b1, !sep_end && !padded && i == len - 1, 1'b0, StatusOk, '0);
    end
    if (padded) begin
      send_word("=", 1'b1, !sep_end && $urandom_range(0, 1) == 0, 1'b0, StatusOk, '0);
      if (!in_ch.end_of_message || sep_end) begin
        if ($urandom_range(0, 1) == 0) begin
          send_word("=", 1'b1, 1'b0, 1'b0, StatusOk, '0);
        end
        if ($urandom_range(0, 2) == 0) begin
          send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, StatusOk, '0);
        end
        sep_end = 1'b1;
      end
    end
    if (sep_end) begin
      send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, StatusOk, '0);
    end
  endtask

  // receiver: switch between always-ready, random and a rotating mask
  int         rx_mode  = 0;
  int         rx_left  = 0;
  int         rx_pos   = 0;
  logic [15:0] rx_mask = 16'hFFFF;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 120);
      rx_mask = 16'($urandom) | 16'h0001;
    end
    rx_left--;
    case (rx_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ch.ready <= rx_mask[rx_pos];
        rx_pos = (rx_pos + 1) % 16;
      end
    endcase
  end

  always @(posedge clk_i) begin
    decoded_t got;
    decoded_t want;
    string    bad;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.out_byte   = out_ch.out_byte;
      got.is_data    = out_ch.is_data;
      got.status     = out_ch.status;
      got.byte_count = out_ch.byte_count;
      got.last       = out_ch.last;
      words_seen++;
      if (got.is_data === 1'b1) bytes_seen++;
      else if (got.status < 3) status_seen[got.status]++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word byte=%h data=%b status=%0d count=%0d last=%b",
                         got.out_byte, got.is_data, got.status, got.byte_count, got.last));
      end else begin
        want = expected_q.pop_front();
        bad = "";
        if (got.out_byte   !== want.out_byte)   bad = {bad, " out_byte"};
        if (got.is_data    !== want.is_data)    bad = {bad, " is_data"};
        if (got.status     !== want.status)     bad = {bad, " status"};
        if (got.byte_count !== want.byte_count) bad = {bad, " byte_count"};
        if (got.last       !== want.last)       bad = {bad, " last"};
        if (bad != "") begin
          report($sformatf("word %0d wrong%s: got %h/%b/%0d/%0d/%b want %h/%b/%0d/%0d/%b",
                           words_seen, bad,
                           got.out_byte, got.is_data, got.status, got.byte_count, got.last,
                           want.out_byte, want.is_data, want.status, want.byte_count,
                           want.last));
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               idle_cycles, expected_q.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.symbol         <= '0;
    in_ch.symbol_present <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    decoder_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == RowCap) begin
        wait_drained();
        write_capacity(DirRows[i].val[CntW-1:0]);
      end else begin
        send_word(DirRows[i].sym, DirRows[i].pres, DirRows[i].eom, DirRows[i].typed,
                  DirRows[i].st, DirRows[i].val[CntW-1:0]);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_capacity(PhaseCaps[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < RandomItems / NumPhases) begin
        send_message();
        // in phase 2, pause mid-phase with the input held until all results are out
        if (p == 2 && items_sent - phase_start >= RandomItems / NumPhases / 2
            && items_sent - phase_start < RandomItems / NumPhases / 2 + 8) begin
          wait_drained();
        end
      end
    end
    wait_drained();

    $display("covered %0d input words over %0d capacity settings", items_sent, cap_writes);
    $display("checked %0d results: %0d bytes, status ok/invalid/overflow %0d/%0d/%0d",
             words_seen, bytes_seen, status_seen[0], status_seen[1], status_seen[2]);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
